// ----- hw/rtl/wpmc_pkg.sv -----
// Shared constants, types and the exponential table of the weighted particle
// mean and covariance core. No dependencies; every other file but wpmc_ram imports it.

package wpmc_pkg;

  // Store size and exponential table resolution.
  localparam int MAX_PARTICLES  = 1024;
  localparam int EXP_TABLE_BITS = 8;
  localparam int ROM_SIZE       = (1 << EXP_TABLE_BITS) + 1;
  localparam int ROM_IDX_W      = EXP_TABLE_BITS + 1;
  localparam int ROM_W          = 32;
  localparam int FRAC_SH        = 16 - EXP_TABLE_BITS;
  localparam int ADDR_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W          = ADDR_W + 1;

  // Field widths.
  localparam int POS_W = 32;
  localparam int LW_W  = 22;
  localparam int W_W   = 32;

  // Weight path: log_weight times log2(e) in Q16 gives a Q32 power of two.
  localparam int LOG2E_Q16     = 94548;
  localparam int LOGW_MAX      = 524287;
  localparam int PROD_W        = 41;
  localparam int K_W           = PROD_W - 32;
  localparam int W_SHIFT_BIAS  = 10;

  // Accumulators and divider.
  localparam int POS_ACC_W = 2 * POS_W + 1 + CNT_W;
  localparam int WSUM_W    = 64;
  localparam int NUM_W     = 128;
  localparam int DEN_W     = 64;
  localparam int Q_W       = 64;
  localparam int STEP_W    = $clog2(NUM_W);
  localparam int E_W       = POS_W + 1;
  localparam int EP_W      = 2 * E_W;

  // Queue between the front and the back.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Stream widths.
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 480;
  localparam int OUT_TUSER_W = 2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WEIGHT = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW    = 2'd2;

  // One particle with its linear weight, as handed from the front to the back.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [W_W-1:0]          weight;
    logic                    last_item;
  } particle_t;

  // Divider request and response.
  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_resp_t;

  typedef logic [ROM_W-1:0] exp_rom_t [ROM_SIZE];

  // Integer square root of a 64-bit value, one result bit per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bits;
    logic [63:0] rest;
    res  = '0;
    bits = 64'd1 << 62;
    rest = v;
    for (int s = 0; s < 32; s++) begin
      if (rest >= res + bits) begin
        rest = rest - (res + bits);
        res  = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Table of 2^(i/2^EXP_TABLE_BITS) in Q2.30, built from repeated square roots.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] root [EXP_TABLE_BITS+1];
    logic [63:0] acc;
    root[0] = 64'd1 << 31;
    for (int b = 1; b <= EXP_TABLE_BITS; b++) begin
      root[b] = isqrt64(root[b-1] << 30);
    end
    for (int i = 0; i < ROM_SIZE; i++) begin
      acc = 64'd1 << 30;
      for (int b = 0; b <= EXP_TABLE_BITS; b++) begin
        if (((i >> b) & 1) != 0) begin
          acc = (acc * root[EXP_TABLE_BITS-b] + (64'd1 << 29)) >> 30;
        end
      end
      rom[i] = acc[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- hw/rtl/wpmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module wpmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/wpmc_front.sv -----
// Front end: accepts particle requests and turns each log weight into a linear
// Q12.20 weight in a three-stage pipeline. Depends on wpmc_pkg.

module wpmc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: pos_x, pos_y, pos_z, log_weight, zero padding (lowest bit first)
  input  logic [wpmc_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                            s_tlast,
  input  logic [wpmc_pkg::QPTR_W:0]       q_count,
  output logic                            item_valid,
  output wpmc_pkg::particle_t             item
);
  import wpmc_pkg::*;

  localparam int QSUM_W = QPTR_W + 2;

  logic                      accept;
  logic signed [LW_W-1:0]    log_weight;
  logic signed [LW_W-1:0]    lw_clamped;
  logic [1:0]                inflight;

  // Stage 1: product with log2(e).
  logic                      v1;
  logic signed [POS_W-1:0]   x1, y1, z1;
  logic                      last1;
  logic signed [PROD_W-1:0]  prod1;

  // Stage 2: table lookup.
  logic                      v2;
  logic signed [POS_W-1:0]   x2, y2, z2;
  logic                      last2;
  logic signed [K_W-1:0]     k2;
  logic [ROM_W-1:0]          lo2;
  logic [ROM_W-1:0]          diff2;
  logic [FRAC_SH-1:0]        rem2;

  // Stage 3: interpolated mantissa.
  logic                      v3;
  logic signed [POS_W-1:0]   x3, y3, z3;
  logic                      last3;
  logic signed [K_W-1:0]     k3;
  logic [ROM_W-1:0]          m3;

  logic [15:0]               frac1;
  logic [EXP_TABLE_BITS-1:0] idx1;
  logic [ROM_IDX_W-1:0]      idx_lo;
  logic [ROM_IDX_W-1:0]      idx_hi;
  logic [ROM_W-1:0]          rom_lo;
  logic [ROM_W-1:0]          rom_hi;
  logic [ROM_W+FRAC_SH-1:0]  interp;
  logic signed [K_W-1:0]     shift3;
  logic [K_W-1:0]            rsh3;
  logic [ROM_W:0]            lsh3;
  logic [W_W-1:0]            weight3;

  // Accept only while the queue has room for this request and all in flight.
  assign inflight = 2'(v1) + 2'(v2) + 2'(v3);
  assign s_tready = (QSUM_W'(q_count) + QSUM_W'(inflight)) < QSUM_W'(QDEPTH);
  assign accept   = s_tvalid && s_tready;
  assign log_weight = $signed(s_tdata[3*POS_W +: LW_W]);

  // Log weights just under 8.0 and above are held at the top of the range.
  assign lw_clamped = (log_weight > LW_W'(LOGW_MAX)) ? LW_W'(LOGW_MAX) : log_weight;

  // Table addressing from the Q16 fraction of the power of two.
  assign frac1  = prod1[31:16];
  assign idx1   = frac1[15:FRAC_SH];
  assign idx_lo = {1'b0, idx1};
  assign idx_hi = idx_lo + ROM_IDX_W'(1);
  assign rom_lo = EXP_ROM[idx_lo];
  assign rom_hi = EXP_ROM[idx_hi];
  assign interp = (ROM_W+FRAC_SH)'(diff2) * (ROM_W+FRAC_SH)'(rem2);

  // Scale the Q2.30 mantissa by 2^k into Q12.20, saturating.
  assign shift3 = k3 - K_W'(W_SHIFT_BIAS);
  assign rsh3   = -shift3;
  assign lsh3   = {1'b0, m3} << shift3[0];
  always_comb begin
    if (!shift3[K_W-1]) begin
      if (shift3 >= K_W'(2) || lsh3[ROM_W]) begin
        weight3 = '1;
      end else begin
        weight3 = lsh3[W_W-1:0];
      end
    end else begin
      weight3 = W_W'(m3 >> rsh3);
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    x1    <= $signed(s_tdata[0 +: POS_W]);
    y1    <= $signed(s_tdata[POS_W +: POS_W]);
    z1    <= $signed(s_tdata[2*POS_W +: POS_W]);
    last1 <= s_tlast;
    prod1 <= $signed({{(PROD_W-LW_W){lw_clamped[LW_W-1]}}, lw_clamped})
             * $signed(PROD_W'(LOG2E_Q16));
    x2    <= x1;
    y2    <= y1;
    z2    <= z1;
    last2 <= last1;
    k2    <= prod1[PROD_W-1:32];
    lo2   <= rom_lo;
    diff2 <= (rom_hi >= rom_lo) ? (rom_hi - rom_lo) : '0;
    rem2  <= frac1[FRAC_SH-1:0];
    x3    <= x2;
    y3    <= y2;
    z3    <= z2;
    last3 <= last2;
    k3    <= k2;
    m3    <= lo2 + ROM_W'(interp >> FRAC_SH);
  end

  assign item_valid     = v3;
  assign item.pos_x     = x3;
  assign item.pos_y     = y3;
  assign item.pos_z     = z3;
  assign item.weight    = weight3;
  assign item.last_item = last3;

endmodule

// ----- hw/rtl/wpmc_fifo.sv -----
// Short queue of weighted particles between the front and the back.
// Depends on wpmc_pkg.

module wpmc_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  wpmc_pkg::particle_t       push_item,
  input  logic                      pop,
  output logic                      out_valid,
  output wpmc_pkg::particle_t       out_item,
  output logic [wpmc_pkg::QPTR_W:0] count
);
  import wpmc_pkg::*;

  particle_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];

  // Pointers and fill level; the front never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/wpmc_div.sv -----
// Shared restoring divider: signed 128-bit numerator by unsigned 64-bit
// divisor, rounded to nearest and saturated to 64 bits. Depends on wpmc_pkg.

module wpmc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  wpmc_pkg::div_req_t   req,
  output wpmc_pkg::div_resp_t  resp
);
  import wpmc_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_PREP = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;
  localparam logic [1:0] DV_FIN  = 2'd3;

  logic [1:0]        state;
  logic              neg;
  logic [NUM_W-1:0]  nq;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;
  logic [Q_W-1:0]    qh;
  logic [Q_W-1:0]    ql;
  logic [Q_W-1:0]    quot_next;

  // One quotient bit per cycle.
  assign rem_sh = {rem, nq[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den});

  // Saturate the magnitude quotient into the signed 64-bit range.
  assign qh = nq[NUM_W-1:Q_W];
  assign ql = nq[Q_W-1:0];
  always_comb begin
    if (neg) begin
      if (qh != '0 || ql > {1'b1, {(Q_W-1){1'b0}}}) begin
        quot_next = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
        quot_next = -ql;
      end
    end else begin
      if (qh != '0 || ql > {1'b0, {(Q_W-1){1'b1}}}) begin
        quot_next = {1'b0, {(Q_W-1){1'b1}}};
      end else begin
        quot_next = ql;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DV_IDLE;
      resp.done <= 1'b0;
    end else begin
      resp.done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (req.start) begin
            state <= DV_PREP;
          end
        end
        DV_PREP: begin
          state <= DV_RUN;
        end
        DV_RUN: begin
          if (step == STEP_W'(NUM_W - 1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          resp.done <= 1'b1;
          state     <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  // Datapath: take the magnitude, add half the divisor, then shift out.
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        neg <= req.num[NUM_W-1];
        nq  <= req.num[NUM_W-1] ? -req.num : req.num;
        den <= req.den;
      end
      DV_PREP: begin
        nq   <= nq + NUM_W'(den >> 1);
        rem  <= '0;
        step <= '0;
      end
      DV_RUN: begin
        rem  <= qbit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        nq   <= {nq[NUM_W-2:0], qbit};
        step <= step + STEP_W'(1);
      end
      DV_FIN: begin
        resp.quot <= quot_next;
      end
      default: begin
        nq <= nq;
      end
    endcase
  end

endmodule

// ----- hw/rtl/wpmc_back.sv -----
// Back end: stores particles, keeps the weight and position sums, and on the
// last particle runs the mean divisions, the covariance pass and its divisions.
// Depends on wpmc_pkg and wpmc_ram; drives the shared divider.

module wpmc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  wpmc_pkg::particle_t              in_item,
  output logic                             in_pop,
  output wpmc_pkg::div_req_t               div_req,
  input  wpmc_pkg::div_resp_t              div_resp,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wpmc_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [wpmc_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import wpmc_pkg::*;

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_SETTLE    = 4'd1;
  localparam logic [3:0] ST_MEAN_GO   = 4'd2;
  localparam logic [3:0] ST_MEAN_WAIT = 4'd3;
  localparam logic [3:0] ST_PASS      = 4'd4;
  localparam logic [3:0] ST_DRAIN     = 4'd5;
  localparam logic [3:0] ST_MOM_GO    = 4'd6;
  localparam logic [3:0] ST_MOM_WAIT  = 4'd7;
  localparam logic [3:0] ST_RESULT    = 4'd8;

  // Axis pairs of the six moments: xx, yy, zz, xy, xz, yz.
  localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

  localparam int PAD_W = OUT_TDATA_W - 3 * POS_W - 3 * (Q_W - 1) - 3 * Q_W;

  logic [3:0]                   state;
  logic [CNT_W-1:0]             count;
  logic                         overflow;
  logic [WSUM_W-1:0]            wsum;
  logic signed [POS_ACC_W-1:0]  pos_sum [3];
  logic signed [NUM_W-1:0]      mom_sum [6];
  logic signed [POS_W-1:0]      mean [3];
  logic [Q_W-1:0]               mom_out [6];
  logic [1:0]                   status;
  logic [2:0]                   idx;
  logic [CNT_W-1:0]             pidx;

  // Load pipeline.
  logic                         store;
  logic                         l1_valid;
  logic signed [POS_W-1:0]      l1_pos [3];
  logic [W_W-1:0]               l1_w;
  logic                         l2_valid;
  logic signed [2*POS_W:0]      l2_prod [3];
  logic [W_W-1:0]               l2_w;

  // Covariance pass pipeline.
  logic                         issue;
  logic                         p1_valid;
  logic [3*POS_W-1:0]           rd_pos;
  logic [W_W-1:0]               rd_w;
  logic                         p2_valid;
  logic signed [E_W-1:0]        p2_e [3];
  logic [W_W-1:0]               p2_w;
  logic                         p3_valid;
  logic signed [EP_W-1:0]       p3_prod [6];
  logic [W_W-1:0]               p3_w;
  logic                         p4_valid;
  logic [E_W+W_W-1:0]           p4_lo [6];
  logic signed [E_W+W_W:0]      p4_hi [6];
  logic                         p5_valid;
  logic signed [NUM_W-1:0]      p5_term [6];

  logic signed [POS_W-1:0]      rd_axis [3];
  logic signed [Q_W-1:0]        qs;
  logic signed [POS_W-1:0]      mean_clamped;

  assign in_pop = in_valid && (state == ST_LOAD);
  assign store  = in_pop && (count < CNT_W'(MAX_PARTICLES));
  assign issue  = (state == ST_PASS);

  // Particle and weight stores.
  wpmc_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({in_item.pos_z, in_item.pos_y, in_item.pos_x}),
    .re    (issue),
    .raddr (pidx[ADDR_W-1:0]),
    .rdata (rd_pos)
  );

  wpmc_ram #(.WIDTH(W_W), .DEPTH(MAX_PARTICLES)) u_w_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count[ADDR_W-1:0]),
    .wdata (in_item.weight),
    .re    (issue),
    .raddr (pidx[ADDR_W-1:0]),
    .rdata (rd_w)
  );

  assign rd_axis[0] = $signed(rd_pos[0 +: POS_W]);
  assign rd_axis[1] = $signed(rd_pos[POS_W +: POS_W]);
  assign rd_axis[2] = $signed(rd_pos[2*POS_W +: POS_W]);

  // Divider requests: a mean uses a position sum, a moment its moment sum.
  always_comb begin
    div_req.start = (state == ST_MEAN_GO) || (state == ST_MOM_GO);
    div_req.den   = wsum;
    if (state == ST_MEAN_GO) begin
      div_req.num = {{(NUM_W-POS_ACC_W){pos_sum[idx[1:0]][POS_ACC_W-1]}}, pos_sum[idx[1:0]]};
    end else begin
      div_req.num = mom_sum[idx];
    end
  end

  // Rounded mean clamped to 32 bits.
  assign qs = $signed(div_resp.quot);
  always_comb begin
    if (qs > $signed(Q_W'({1'b0, {(POS_W-1){1'b1}}}))) begin
      mean_clamped = {1'b0, {(POS_W-1){1'b1}}};
    end else if (qs < -$signed(Q_W'({1'b1, {(POS_W-1){1'b0}}}))) begin
      mean_clamped = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      mean_clamped = qs[POS_W-1:0];
    end
  end

  // Datapath pipelines: products during load and during the covariance pass.
  always_ff @(posedge clk) begin
    l1_pos[0] <= in_item.pos_x;
    l1_pos[1] <= in_item.pos_y;
    l1_pos[2] <= in_item.pos_z;
    l1_w      <= in_item.weight;
    for (int a = 0; a < 3; a++) begin
      l2_prod[a] <= l1_pos[a] * $signed({1'b0, l1_w});
      p2_e[a]    <= $signed({rd_axis[a][POS_W-1], rd_axis[a]})
                    - $signed({mean[a][POS_W-1], mean[a]});
    end
    l2_w <= l1_w;
    p2_w <= rd_w;
    p3_w <= p2_w;
    for (int m = 0; m < 6; m++) begin
      p3_prod[m] <= p2_e[PA[m]] * p2_e[PB[m]];
      p4_lo[m]   <= (E_W+W_W)'(p3_prod[m][E_W-1:0]) * (E_W+W_W)'(p3_w);
      p4_hi[m]   <= $signed(p3_prod[m][EP_W-1:E_W]) * $signed({1'b0, p3_w});
      p5_term[m] <= ($signed({{(NUM_W-E_W-W_W-1){p4_hi[m][E_W+W_W]}}, p4_hi[m]}) <<< E_W)
                    + $signed(NUM_W'(p4_lo[m]));
    end
  end

  // Control, sums and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      wsum     <= '0;
      idx      <= '0;
      pidx     <= '0;
      l1_valid <= 1'b0;
      l2_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        pos_sum[a] <= '0;
      end
      for (int m = 0; m < 6; m++) begin
        mom_sum[m] <= '0;
      end
    end else begin
      l1_valid <= store;
      l2_valid <= l1_valid;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;

      // Running sums of the loaded set.
      if (l2_valid) begin
        wsum <= wsum + WSUM_W'(l2_w);
        for (int a = 0; a < 3; a++) begin
          pos_sum[a] <= pos_sum[a]
                        + {{(POS_ACC_W-2*POS_W-1){l2_prod[a][2*POS_W]}}, l2_prod[a]};
        end
      end
      if (p5_valid) begin
        for (int m = 0; m < 6; m++) begin
          mom_sum[m] <= mom_sum[m] + p5_term[m];
        end
      end

      case (state)
        // Take particles; those past the store size only mark the overflow.
        ST_LOAD: begin
          if (in_pop) begin
            if (store) begin
              count <= count + CNT_W'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (in_item.last_item) begin
              state <= ST_SETTLE;
            end
          end
        end
        // Let the last products reach the sums.
        ST_SETTLE: begin
          if (!l1_valid && !l2_valid) begin
            idx <= '0;
            for (int a = 0; a < 3; a++) begin
              mean[a] <= '0;
            end
            for (int m = 0; m < 6; m++) begin
              mom_out[m] <= '0;
            end
            if (wsum == '0) begin
              status <= STATUS_ZERO_WEIGHT;
              state  <= ST_RESULT;
            end else begin
              status <= overflow ? STATUS_OVERFLOW : STATUS_OK;
              state  <= ST_MEAN_GO;
            end
          end
        end
        ST_MEAN_GO: begin
          state <= ST_MEAN_WAIT;
        end
        ST_MEAN_WAIT: begin
          if (div_resp.done) begin
            mean[idx[1:0]] <= mean_clamped;
            if (idx == 3'd2) begin
              idx  <= '0;
              pidx <= '0;
              state <= (count >= CNT_W'(2)) ? ST_PASS : ST_RESULT;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_MEAN_GO;
            end
          end
        end
        // Second pass: one stored particle read per cycle.
        ST_PASS: begin
          if (pidx == count - CNT_W'(1)) begin
            state <= ST_DRAIN;
          end else begin
            pidx <= pidx + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!p1_valid && !p2_valid && !p3_valid && !p4_valid && !p5_valid) begin
            idx   <= '0;
            state <= ST_MOM_GO;
          end
        end
        ST_MOM_GO: begin
          state <= ST_MOM_WAIT;
        end
        ST_MOM_WAIT: begin
          if (div_resp.done) begin
            if (idx < 3'd3) begin
              mom_out[idx] <= div_resp.quot[Q_W-1] ? '0
                              : {1'b0, div_resp.quot[Q_W-2:0]};
            end else begin
              mom_out[idx] <= div_resp.quot;
            end
            if (idx == 3'd5) begin
              state <= ST_RESULT;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_MOM_GO;
            end
          end
        end
        // Hold the result until the request is taken, then clear the set.
        ST_RESULT: begin
          if (m_tready) begin
            count    <= '0;
            overflow <= 1'b0;
            wsum     <= '0;
            for (int a = 0; a < 3; a++) begin
              pos_sum[a] <= '0;
            end
            for (int m = 0; m < 6; m++) begin
              mom_sum[m] <= '0;
            end
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output request.
  assign m_tvalid = (state == ST_RESULT);
  assign m_tuser  = status;
  assign m_tdata  = {{PAD_W{1'b0}},
                     mom_out[5], mom_out[4], mom_out[3],
                     mom_out[2][Q_W-2:0], mom_out[1][Q_W-2:0], mom_out[0][Q_W-2:0],
                     mean[2], mean[1], mean[0]};

endmodule

// ----- hw/rtl/weighted_particle_mean_covariance_core.sv -----
// Top level of the weighted particle mean and covariance core.
// Depends on wpmc_pkg, wpmc_front, wpmc_fifo, wpmc_div, wpmc_back, wpmc_ram.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: pos_x, pos_y, pos_z, log_weight; tlast: last_item
//   m_*      out        tdata: mean_x..z, var_xx..zz, cov_xy, cov_xz, cov_yz;
//                       tuser: status
//
// Particles are taken one per cycle while the queue has room; the front
// pipeline computes each weight in its product, lookup and interpolation stages.
// After the last particle the back runs the mean and moment divisions in the
// shared one-bit-per-cycle divider and the covariance pass over the store, one
// store read per cycle; input stalls once the queue fills.
// Reset is synchronous; the stores need no clearing and the core is ready
// the cycle after reset drops. The result waits in registers for m_tready.

module weighted_particle_mean_covariance_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: pos_x, pos_y, pos_z, log_weight, zero padding (lowest bit first)
  input  logic [wpmc_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: mean_x, mean_y, mean_z, var_xx, var_yy, var_zz, cov_xy, cov_xz,
  // cov_yz, zero padding (lowest bit first)
  output logic [wpmc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: status
  output logic [wpmc_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import wpmc_pkg::*;

  logic        f_valid;
  particle_t   f_item;
  logic        q_valid;
  particle_t   q_item;
  logic        q_pop;
  logic [QPTR_W:0] q_count;
  div_req_t    div_req;
  div_resp_t   div_resp;

  // Weight computation.
  wpmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_count    (q_count),
    .item_valid (f_valid),
    .item       (f_item)
  );

  // Decoupling queue.
  wpmc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_item  (q_item),
    .count     (q_count)
  );

  // Shared divider.
  wpmc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // Storage, sums and finishing passes.
  wpmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_pop   (q_pop),
    .div_req  (div_req),
    .div_resp (div_resp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
